// ----- hw/rtl/etc_pkg.sv -----
// ----------------------------------------------------------------------------
// etc_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package etc_pkg;

    localparam int unsigned IN_W    = 32;
    localparam int unsigned OUT_W   = 40;
    localparam int unsigned REM_W   = 17;
    localparam int unsigned QUO_W   = 16;
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 26;
    localparam int unsigned PROD_W  = 51;

    localparam logic [1:0] OP_DAY  = 2'd0;
    localparam logic [1:0] OP_HOUR = 2'd1;
    localparam logic [1:0] OP_MIN  = 2'd2;
    localparam logic [1:0] OP_CYC  = 2'd3;

    localparam logic [REM_W-1:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [REM_W-1:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [REM_W-1:0] SECS_PER_MIN   = 17'd60;
    localparam logic [REM_W-1:0] DAYS_PER_4Y    = 17'd1461;

    // reciprocals of the odd parts 675, 225, 15 and 1461, scaled by 2^K
    localparam logic [MUL_B_W-1:0] RECIP_DAY  = 26'd50903317;
    localparam logic [MUL_B_W-1:0] RECIP_HOUR = 26'd9321;
    localparam logic [MUL_B_W-1:0] RECIP_MIN  = 26'd1093;
    localparam logic [MUL_B_W-1:0] RECIP_4Y   = 26'd91868;

    localparam int unsigned K_DAY  = 35;
    localparam int unsigned K_HOUR = 21;
    localparam int unsigned K_MIN  = 14;
    localparam int unsigned K_4Y   = 27;

    // day offset of 1970-01-01 from 1968-03-01, and of 2100-03-01
    localparam logic [15:0] DAY_SHIFT    = 16'd671;
    localparam logic [15:0] DAY_MAR_2100 = 16'd48212;
    localparam logic [11:0] BASE_YEAR    = 12'd1968;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [1:0] op;
        logic       yoc_en;
        logic       out_en;
    } etc_cmd_t;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/etc_div.sv -----
// ----------------------------------------------------------------------------
// etc_div
// Shared constant divider: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [1:0]                    op,
    input  wire logic [etc_pkg::IN_W-1:0]      dividend,
    output logic                               done,
    output logic [etc_pkg::REM_W-1:0]          rem,
    output logic [etc_pkg::QUO_W-1:0]          quo
);

    logic [1:0]                    op_reg;
    logic [etc_pkg::IN_W-1:0]      x_reg;
    logic [etc_pkg::PROD_W-1:0]    prod_reg;
    logic [etc_pkg::REM_W-1:0]     rem_reg;
    logic [etc_pkg::QUO_W-1:0]     quo_reg;
    logic [1:0]                    cnt_reg, cnt_next;
    logic [etc_pkg::MUL_A_W-1:0]   mul_a;
    logic [etc_pkg::MUL_B_W-1:0]   mul_b;
    logic [etc_pkg::REM_W-1:0]     div_c;
    logic [etc_pkg::QUO_W-1:0]     quo_w;

    // drop the power-of-two factor of the divisor before the multiply
    always_comb
    begin
        case (op_reg)
            etc_pkg::OP_DAY:
            begin
                mul_a = x_reg[31:7];
                mul_b = etc_pkg::RECIP_DAY;
                div_c = etc_pkg::SECS_PER_DAY;
                quo_w = prod_reg[etc_pkg::K_DAY +: etc_pkg::QUO_W];
            end
            etc_pkg::OP_HOUR:
            begin
                mul_a = {12'd0, x_reg[16:4]};
                mul_b = etc_pkg::RECIP_HOUR;
                div_c = etc_pkg::SECS_PER_HOUR;
                quo_w = prod_reg[etc_pkg::K_HOUR +: etc_pkg::QUO_W];
            end
            etc_pkg::OP_MIN:
            begin
                mul_a = {15'd0, x_reg[11:2]};
                mul_b = etc_pkg::RECIP_MIN;
                div_c = etc_pkg::SECS_PER_MIN;
                quo_w = prod_reg[etc_pkg::K_MIN +: etc_pkg::QUO_W];
            end
            default:
            begin
                mul_a = {9'd0, x_reg[15:0]};
                mul_b = etc_pkg::RECIP_4Y;
                div_c = etc_pkg::DAYS_PER_4Y;
                quo_w = prod_reg[etc_pkg::K_4Y +: etc_pkg::QUO_W];
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = 2'd2;
        end
        else if (cnt_reg != 2'd0)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= op;
            x_reg  <= dividend;
        end
        if (cnt_reg == 2'd2)
        begin
            prod_reg <= {{(etc_pkg::PROD_W - etc_pkg::MUL_A_W){1'b0}}, mul_a}
                        * {{(etc_pkg::PROD_W - etc_pkg::MUL_B_W){1'b0}}, mul_b};
        end
        if (cnt_reg == 2'd1)
        begin
            quo_reg <= quo_w;
            rem_reg <= x_reg[etc_pkg::REM_W-1:0] - ({1'b0, quo_w} * div_c);
        end
    end

    assign done = (cnt_reg == 2'd0);
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/etc_datapath.sv -----
// ----------------------------------------------------------------------------
// etc_datapath
// Operand muxing around the shared divider and the calendar arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire etc_pkg::etc_cmd_t          cmd,
    input  wire logic [etc_pkg::IN_W-1:0]   in_data,
    output logic                            div_done,
    output logic [etc_pkg::OUT_W-1:0]       out_data
);

    logic [etc_pkg::IN_W-1:0]   t_reg;
    logic [15:0]                days_reg;
    logic [4:0]                 hour_reg;
    logic [5:0]                 minute_reg;
    logic [5:0]                 second_reg;
    logic [5:0]                 cycle_reg;
    logic [1:0]                 yoc_reg;
    logic [8:0]                 doy_reg;
    logic [etc_pkg::OUT_W-1:0]  out_reg;

    logic [etc_pkg::IN_W-1:0]   dividend;
    logic [etc_pkg::REM_W-1:0]  rem;
    logic [etc_pkg::QUO_W-1:0]  quo;

    logic [15:0] d0;
    logic [15:0] d1;
    logic [10:0] r4;
    logic [1:0]  yoc;
    logic [10:0] yoff;
    logic [10:0] doy_w;
    logic [3:0]  mp;
    logic [8:0]  mstart;
    logic [8:0]  dom_w;
    logic [3:0]  month;
    logic [11:0] year;

    etc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .op       (cmd.op),
        .dividend (dividend),
        .done     (div_done),
        .rem      (rem),
        .quo      (quo)
    );

    // insert a phantom 2100-02-29 so every four-year cycle is 1461 days
    assign d0 = days_reg + etc_pkg::DAY_SHIFT;
    assign d1 = (d0 >= etc_pkg::DAY_MAR_2100) ? d0 + 16'd1 : d0;

    always_comb
    begin
        case (cmd.op)
            etc_pkg::OP_DAY:
            begin
                dividend = t_reg;
            end
            etc_pkg::OP_HOUR:
            begin
                dividend = {15'd0, rem};
            end
            etc_pkg::OP_MIN:
            begin
                dividend = {15'd0, rem};
            end
            default:
            begin
                dividend = {16'd0, d1};
            end
        endcase
    end

    assign r4 = rem[10:0];

    always_comb
    begin
        if (r4 >= 11'd1095)
        begin
            yoc  = 2'd3;
            yoff = 11'd1095;
        end
        else if (r4 >= 11'd730)
        begin
            yoc  = 2'd2;
            yoff = 11'd730;
        end
        else if (r4 >= 11'd365)
        begin
            yoc  = 2'd1;
            yoff = 11'd365;
        end
        else
        begin
            yoc  = 2'd0;
            yoff = 11'd0;
        end
    end

    assign doy_w = r4 - yoff;

    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy_reg >= etc_pkg::month_start(4'(i)))
            begin
                mp = 4'(i);
            end
        end
    end

    assign mstart = etc_pkg::month_start(mp);
    assign dom_w  = doy_reg - mstart + 9'd1;
    assign month  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    assign year   = etc_pkg::BASE_YEAR + {4'd0, cycle_reg, 2'd0} + {10'd0, yoc_reg}
                    + {11'd0, (mp >= 4'd10)};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg <= in_data;
        end
        if (cmd.start && cmd.op == etc_pkg::OP_HOUR)
        begin
            days_reg <= quo;
        end
        if (cmd.start && cmd.op == etc_pkg::OP_MIN)
        begin
            hour_reg <= quo[4:0];
        end
        if (cmd.start && cmd.op == etc_pkg::OP_CYC)
        begin
            minute_reg <= quo[5:0];
            second_reg <= rem[5:0];
        end
        if (cmd.yoc_en)
        begin
            cycle_reg <= quo[5:0];
            yoc_reg   <= yoc;
            doy_reg   <= doy_w[8:0];
        end
        if (cmd.out_en)
        begin
            out_reg <= {2'd0, second_reg, minute_reg, hour_reg, dom_w[4:0], month, year};
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/etc_ctrl.sv -----
// ----------------------------------------------------------------------------
// etc_ctrl
// Sequencer for the conversion steps and the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire logic           div_done,
    output etc_pkg::etc_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DAY   = 3'd2;
    localparam logic [2:0] S_HOUR  = 3'd3;
    localparam logic [2:0] S_MIN   = 3'd4;
    localparam logic [2:0] S_CYC   = 3'd5;
    localparam logic [2:0] S_YEAR  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = etc_pkg::OP_DAY;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                cmd.op     = etc_pkg::OP_DAY;
                state_next = S_DAY;
            end
            S_DAY:
            begin
                if (div_done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = etc_pkg::OP_HOUR;
                    state_next = S_HOUR;
                end
            end
            S_HOUR:
            begin
                if (div_done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = etc_pkg::OP_MIN;
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                if (div_done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = etc_pkg::OP_CYC;
                    state_next = S_CYC;
                end
            end
            S_CYC:
            begin
                if (div_done)
                begin
                    cmd.yoc_en = 1'b1;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (out_free)
                begin
                    cmd.out_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_en)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unix seconds to Gregorian UTC date and time of day.
//
// Input stream: s_tdata carries a 32-bit unsigned count of seconds since
// 1970-01-01 00:00:00 UTC. Output stream: one transfer per input with year,
// month, day of month, hour, minute and second packed in m_tdata.
// One item at a time runs through a shared constant divider that multiplies
// by a reciprocal and then forms the remainder, for seconds per day, per
// hour and per minute and days per four-year cycle, then one step each for
// year-in-cycle and month lookup. A new input is taken only after the
// result has been written to the result register.
// The result register holds the previous result while the next item is
// taken and computed; if the receiver still stalls when the next result is
// ready, the block holds it and takes no input until the transfer.
// Reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [etc_pkg::IN_W-1:0]   s_tdata,   // epoch_seconds[31:0]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // year[11:0], month[15:12], day_of_month[20:16], hour[25:21],
    // minute[31:26], second[37:32], zero fill[39:38]
    output logic [etc_pkg::OUT_W-1:0]       m_tdata
);

    etc_pkg::etc_cmd_t cmd;
    logic              div_done;

    etc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .div_done (div_done),
        .cmd      (cmd)
    );

    etc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .div_done (div_done),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sim/epoch_seconds_to_calendar_tb.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// Self-checking bench for the Unix seconds to UTC calendar converter.
//
// Every input transfer is converted by a year-by-year, month-by-month
// calendar walk in the bench. The expected dates are queued in order and
// each output transfer is compared field by field with the oldest one.
// Stimulus covers range ends, day, month and year rollovers, leap day 2000,
// non-leap 2100, and random counts biased toward day and year boundaries.
// Both stream sides insert random idle cycles, with one stretch without
// idling and one pause until all results are back.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 40;

    // lowest field last, matching the m_tdata packing
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [etc_pkg::IN_W-1:0]     s_tdata = '0;      // epoch_seconds[31:0]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // year[11:0], month[15:12], day_of_month[20:16], hour[25:21],
    // minute[31:26], second[37:32], zero fill[39:38]
    logic [etc_pkg::OUT_W-1:0]    m_tdata;

    calendar_t    pending_dates[$];
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    bit           steady_flow = 1'b0;

    epoch_seconds_to_calendar u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // walk whole years, then whole months, from 1970-01-01
    function automatic calendar_t calendar_of(input logic [31:0] secs);
        calendar_t    c;
        int unsigned  days;
        int unsigned  y;
        int unsigned  m;
        int unsigned  len;
        int unsigned  month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        c.second = 6'(secs % 60);
        c.minute = 6'((secs / 60) % 60);
        c.hour   = 5'((secs / 3600) % 24);
        days     = secs / 86400;
        y = 1970;
        while (days >= (is_leap(y) ? 366 : 365))
        begin
            days -= is_leap(y) ? 366 : 365;
            y++;
        end
        m = 0;
        len = month_len[0];
        while (days >= len)
        begin
            days -= len;
            m++;
            len = month_len[m] + ((m == 1 && is_leap(y)) ? 1 : 0);
        end
        c.year         = 12'(y);
        c.month        = 4'(m + 1);
        c.day_of_month = 5'(days + 1);
        return c;
    endfunction

    // seconds near day ends, New Year and March 1, or anywhere in range
    function automatic logic [31:0] random_stamp();
        longint       secs;
        int unsigned  y;
        longint       days;
        case ($urandom_range(0, 3))
            0: secs = $urandom();
            1:
            begin
                secs = longint'($urandom_range(0, 49710)) * 86400;
                case ($urandom_range(0, 2))
                    0: secs += 86399;
                    1: secs += $urandom_range(0, 86399);
                    default: ;
                endcase
            end
            default:
            begin
                y = $urandom_range(1971, 2106);
                days = (y - 1970) * 365 + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400) - 477;
                if ($urandom_range(0, 1))
                    days += 59 + (is_leap(y) ? 1 : 0);
                secs = days * 86400 + $urandom_range(0, 2 * 86400) - 86400;
            end
        endcase
        if (secs < 0 || secs > 64'hFFFF_FFFF)
            secs = $urandom();
        return secs[31:0];
    endfunction

    task automatic send_stamp(input logic [31:0] secs);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_all_dates();
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    task automatic test_calendar_edges();
        logic [31:0] stamps[$] = '{
            32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
            32'd86399, 32'd86400, 32'hAAAA_AAAA, 32'h5555_5555,
            32'd94608000, 32'd94694399, 32'd94694400,
            32'd946684799, 32'd951782399, 32'd951782400, 32'd951868800,
            32'd978220800, 32'd978307200,
            32'd2147483647, 32'd2147483648,
            32'd4107456000, 32'd4107542399, 32'd4107542400,
            32'd4260124800
        };
        foreach (stamps[i])
            send_stamp(stamps[i]);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        repeat (count)
            send_stamp(random_stamp());
    endtask

    task automatic test_steady_flow(input int unsigned count);
        steady_flow = 1'b1;
        repeat (count)
            send_stamp(random_stamp());
        steady_flow = 1'b0;
    endtask

    task automatic test_drain_pause(input int unsigned count);
        repeat (count / 2)
            send_stamp(random_stamp());
        s_tvalid <= 1'b0;
        wait_all_dates();
        repeat (count - count / 2)
            send_stamp(random_stamp());
    endtask

    always @(posedge clk)
    begin
        calendar_t got;
        calendar_t exp_date;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_dates.push_back(calendar_of(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[37:0];
                if (pending_dates.size() == 0)
                begin
                    $error("unexpected result transfer %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    exp_date = pending_dates.pop_front();
                    check_field("year", exp_date.year, got.year);
                    check_field("month", exp_date.month, got.month);
                    check_field("day_of_month", exp_date.day_of_month, got.day_of_month);
                    check_field("hour", exp_date.hour, got.hour);
                    check_field("minute", exp_date.minute, got.minute);
                    check_field("second", exp_date.second, got.second);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("epoch_seconds_to_calendar verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_edges();
        test_random_traffic(1000);
        test_steady_flow(200);
        test_drain_pause(150);
        s_tvalid <= 1'b0;
        wait_all_dates();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_dates.size() == 0)
            $display("epoch_seconds_to_calendar verification clean");
        else
            $display("epoch_seconds_to_calendar verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/etc_pkg.sv
hw/rtl/etc_div.sv
hw/rtl/etc_datapath.sv
hw/rtl/etc_ctrl.sv
hw/rtl/epoch_seconds_to_calendar.sv
sim/epoch_seconds_to_calendar_tb.sv
